// File: rtl/core/mbps_pkg.sv
// mbps_pkg: shared types and constants of the masked byte pattern scanner
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mbps_pkg;

    // fixed field widths
    localparam int AddrW    = 48;
    localparam int RegW     = 64;
    localparam int PatMax   = 16;
    localparam int LenW     = 5;
    localparam int IdxW     = 4;
    localparam int CareW    = 16;
    localparam int MaxmW    = 11;
    localparam int RegAddrW = 6;

    // defaults for the top level parameters
    localparam int PatternBytesDef  = 16;
    localparam int MaxMatchLimitDef = 1024;

    // register reset values
    localparam logic [CareW-1:0] CareRst = 16'hFFFF;
    localparam logic [LenW-1:0]  LenRst  = 5'd1;
    localparam logic [MaxmW-1:0] MaxmRst = 11'd1024;

    // register index, byte address is 8 times this
    typedef enum logic [2:0] {
        RegPatLow,
        RegPatHigh,
        RegCare,
        RegPatLen,
        RegRangeStart,
        RegRangeEnd,
        RegMaxMatches
    } t_reg_idx;

    // register file contents
    typedef struct packed {
        logic [RegW-1:0]  pat_lo;
        logic [RegW-1:0]  pat_hi;
        logic [CareW-1:0] care;
        logic [LenW-1:0]  plen;
        logic [AddrW-1:0] rstart;
        logic [AddrW-1:0] rend;
        logic [MaxmW-1:0] maxm;
    } t_cfg;

    // compare settings broadcast to every cell
    typedef struct packed {
        logic [LenW-1:0]              len;
        logic [PatMax-1:0][7:0]       pat;
        logic [CareW-1:0]             care;
    } t_cmp_cfg;

    // window control broadcast to every cell
    typedef struct packed {
        logic shift;  // in-range byte enters the chain
        logic clear;  // window restarts with this byte
        logic flush;  // out-of-range byte empties the window
    } t_cell_ctl;

endpackage

// File: rtl/core/mbps_regs.sv
// mbps_regs: apb register file holding pattern, mask, length, range and limit
// depends on mbps_pkg
`timescale 1ns / 1ps

module mbps_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mbps_pkg::RegAddrW-1:0]  paddr,
    input  logic [mbps_pkg::RegW-1:0]      pwdata,
    output logic [mbps_pkg::RegW-1:0]      prdata,
    output logic                           pready,
    output mbps_pkg::t_cfg                 o_cfg
);
    import mbps_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[RegAddrW-1:3]);
    assign w_wr   = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pat_lo <= '0;
            r_cfg.pat_hi <= '0;
            r_cfg.care   <= CareRst;
            r_cfg.plen   <= LenRst;
            r_cfg.rstart <= '0;
            r_cfg.rend   <= '0;
            r_cfg.maxm   <= MaxmRst;
        end else if (w_wr) begin
            case (w_idx)
                RegPatLow:     r_cfg.pat_lo <= pwdata;
                RegPatHigh:    r_cfg.pat_hi <= pwdata;
                RegCare:       r_cfg.care   <= pwdata[CareW-1:0];
                RegPatLen:     r_cfg.plen   <= pwdata[LenW-1:0];
                RegRangeStart: r_cfg.rstart <= pwdata[AddrW-1:0];
                RegRangeEnd:   r_cfg.rend   <= pwdata[AddrW-1:0];
                RegMaxMatches: r_cfg.maxm   <= pwdata[MaxmW-1:0];
                default: begin
                end
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            RegPatLow:     prdata = r_cfg.pat_lo;
            RegPatHigh:    prdata = r_cfg.pat_hi;
            RegCare:       prdata = RegW'(r_cfg.care);
            RegPatLen:     prdata = RegW'(r_cfg.plen);
            RegRangeStart: prdata = RegW'(r_cfg.rstart);
            RegRangeEnd:   prdata = RegW'(r_cfg.rend);
            RegMaxMatches: prdata = RegW'(r_cfg.maxm);
            default:       prdata = '0;
        endcase
    end

endmodule

// File: rtl/core/mbps_cell.sv
// mbps_cell: one window position, holds a byte and its valid flag and compares
// it against the pattern byte that lines up with it; depends on mbps_pkg
`timescale 1ns / 1ps

module mbps_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mbps_pkg::t_cell_ctl  i_ctl,
    input  mbps_pkg::t_cmp_cfg   i_cfg,
    input  logic [7:0]           i_byte,
    input  logic                 i_vld,
    output logic [7:0]           o_byte,
    output logic                 o_vld,
    output logic                 o_ok
);
    import mbps_pkg::*;

    localparam logic            IsHead  = (CELL_IDX == 0);
    localparam logic            InReach = (CELL_IDX < PatMax);
    localparam logic [LenW-1:0] KPos    = LenW'(CELL_IDX);

    logic [7:0]      r_byte;
    logic            r_vld;
    logic            w_use;
    logic [IdxW-1:0] w_idx;

    // byte shifts in from the neighbor, payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_byte <= i_byte;
        end
    end

    // valid flag follows the byte, cleared on flush and, in all cells but cell 0, on window restart
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.flush) begin
            r_vld <= 1'b0;
        end else if (i_ctl.shift) begin
            r_vld <= i_ctl.clear ? IsHead : i_vld;
        end
    end

    // newest byte sits at cell 0, so this cell meets pattern byte len-1-k
    assign w_use = InReach && (KPos < i_cfg.len);
    assign w_idx = IdxW'(i_cfg.len - LenW'(1) - KPos);
    assign o_ok  = !w_use || !i_cfg.care[w_idx] || (r_byte == i_cfg.pat[w_idx]);

    assign o_byte = r_byte;
    assign o_vld  = r_vld;

endmodule

// File: rtl/core/masked_byte_pattern_scan.sv
// masked_byte_pattern_scan: top level, chain of window cells, compare stage,
// output register and apb registers; depends on mbps_pkg, mbps_cell, mbps_regs
//
//   channel   dir  handshake                   payload
//   s_*       in   s_tvalid/s_tready           tdata: byte, address; tuser: flags
//   m_*       out  m_tvalid/m_tready           tdata: address, low, high; tuser: limit
//   apb       in   psel/penable/pwrite/pready  64-bit registers at 8*index
//
// one byte per cycle sustained while the output is not stalled; a byte enters the
// cell chain at its beat, the compare runs the next cycle off the cell outputs,
// and the result is held in the output register.
// reset is synchronous and clears valid flags, the match count and registers.
// a stalled output backs up into the compare stage, then holds s_tready low.
`timescale 1ns / 1ps

module masked_byte_pattern_scan #(
    parameter int PATTERN_BYTES   = mbps_pkg::PatternBytesDef,
    parameter int MAX_MATCH_LIMIT = mbps_pkg::MaxMatchLimitDef
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [55:0]                    s_tdata,  // data_byte, byte_address
    input  logic [1:0]                     s_tuser,  // region_first, scan_first
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [175:0]                   m_tdata,  // match_address, matched_low,
                                                     // matched_high
    output logic [0:0]                     m_tuser,  // limit_reached
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mbps_pkg::RegAddrW-1:0]  paddr,
    input  logic [mbps_pkg::RegW-1:0]      pwdata,
    output logic [mbps_pkg::RegW-1:0]      prdata,
    output logic                           pready
);
    import mbps_pkg::*;

    localparam int LenMax = (PATTERN_BYTES < PatMax) ? PATTERN_BYTES : PatMax;
    localparam int CntW   = $clog2(MAX_MATCH_LIMIT + 1);
    localparam int LimW   = (CntW > MaxmW) ? CntW : MaxmW;
    localparam logic [LimW-1:0] LimMax = LimW'(MAX_MATCH_LIMIT);

    t_cfg       w_cfg;
    t_cmp_cfg   w_cmp;
    t_cell_ctl  w_ctl;

    logic [7:0]       w_in_byte;
    logic [AddrW-1:0] w_in_addr;
    logic             w_accept;
    logic             w_in_range;
    logic             w_out_free;
    logic             w_advance;
    logic             w_hit;
    logic             w_emit;
    logic             w_full;
    logic             w_all_ok;
    logic             w_last;
    logic [LenW-1:0]  w_len;
    logic [CntW-1:0]  w_limit;
    logic [PatMax-1:0][7:0] w_matched;

    logic [7:0] w_byte [PATTERN_BYTES];
    logic       w_vld  [PATTERN_BYTES];
    logic       w_ok   [PATTERN_BYTES];

    logic             r_s1_vld;
    logic [AddrW-1:0] r_s1_addr;
    logic [CntW-1:0]  r_count;
    logic             r_out_vld;
    logic [175:0]     r_out_data;
    logic             r_out_last;

    // register file
    mbps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // used length saturates at the window depth and at sixteen
    assign w_len = (w_cfg.plen > LenW'(LenMax)) ? LenW'(LenMax) : w_cfg.plen;

    assign w_cmp.len  = w_len;
    assign w_cmp.pat  = {w_cfg.pat_hi, w_cfg.pat_lo};
    assign w_cmp.care = w_cfg.care;

    // input beat and range test
    assign w_in_byte  = s_tdata[7:0];
    assign w_in_addr  = s_tdata[55:8];
    assign w_accept   = s_tvalid & s_tready;
    assign w_in_range = !(((w_cfg.rstart != '0) && (w_in_addr < w_cfg.rstart)) ||
                          ((w_cfg.rend != '0) && (w_in_addr >= w_cfg.rend)));

    assign w_ctl.shift = w_accept & w_in_range;
    assign w_ctl.clear = s_tuser[0] | s_tuser[1];
    assign w_ctl.flush = w_accept & !w_in_range;

    // flow control between the stages
    assign w_out_free = !r_out_vld || m_tready;
    assign s_tready   = !r_s1_vld || w_out_free;
    assign w_advance  = r_s1_vld && w_out_free;

    // window cells, cell 0 holds the newest byte
    for (genvar k = 0; k < PATTERN_BYTES; k++) begin : g_cell
        if (k == 0) begin : g_head
            mbps_cell #(.CELL_IDX(k)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_cfg   (w_cmp),
                .i_byte  (w_in_byte),
                .i_vld   (1'b1),
                .o_byte  (w_byte[k]),
                .o_vld   (w_vld[k]),
                .o_ok    (w_ok[k])
            );
        end else begin : g_body
            mbps_cell #(.CELL_IDX(k)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_cfg   (w_cmp),
                .i_byte  (w_byte[k-1]),
                .i_vld   (w_vld[k-1]),
                .o_byte  (w_byte[k]),
                .o_vld   (w_vld[k]),
                .o_ok    (w_ok[k])
            );
        end
    end

    // window fill check and and-reduction of the cell compares
    always_comb begin
        w_full   = 1'b0;
        w_all_ok = 1'b1;
        for (int k = 0; k < PATTERN_BYTES; k++) begin
            w_all_ok = w_all_ok & w_ok[k];
        end
        for (int k = 0; k < LenMax; k++) begin
            if (w_len == LenW'(k + 1)) begin
                w_full = w_vld[k];
            end
        end
    end

    // matched bytes in pattern order, zero past the length
    always_comb begin
        w_matched = '0;
        for (int i = 0; i < PatMax; i++) begin
            for (int k = 0; k < LenMax; k++) begin
                if (w_len == LenW'(k + i + 1)) begin
                    w_matched[i] = w_byte[k];
                end
            end
        end
    end

    // match limit, zero acts as one, saturates at the parameter
    always_comb begin
        logic [LimW-1:0] m;
        m = LimW'(w_cfg.maxm);
        if (m == '0) begin
            m = LimW'(1);
        end
        if (m > LimMax) begin
            m = LimMax;
        end
        w_limit = CntW'(m);
    end

    assign w_hit  = (w_len != '0) && w_full && w_all_ok && (r_count < w_limit);
    assign w_emit = w_advance && w_hit;
    assign w_last = ({1'b0, r_count} + (CntW+1)'(1)) >= {1'b0, w_limit};

    // compare stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_tready) begin
            r_s1_vld <= w_accept & w_in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_addr <= w_in_addr;
        end
    end

    // match count, a new scan wins over a match of the previous byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept && s_tuser[1]) begin
            r_count <= '0;
        end else if (w_emit) begin
            r_count <= r_count + CntW'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= {w_matched,
                           AddrW'(r_s1_addr - AddrW'(w_len - LenW'(1)))};
            r_out_last <= w_last;
        end
    end

    assign m_tvalid   = r_out_vld;
    assign m_tdata    = r_out_data;
    assign m_tuser[0] = r_out_last;

endmodule
